// ===== rtl/core/keyed_byte_round_cipher_assert.svh =====
// Assertion macros used by the cipher RTL.
`ifndef KEYED_BYTE_ROUND_CIPHER_ASSERT_SVH
`define KEYED_BYTE_ROUND_CIPHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define KBRC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KBRC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/kbrc_pkg.sv =====
// Constants, types and codes of the keyed byte round cipher.
package kbrc_pkg;

   localparam int unsigned BYTE_W           = 8;
   localparam int unsigned KEY_DEPTH        = 64;
   localparam int unsigned KEY_IDX_W        = $clog2(KEY_DEPTH);
   localparam int unsigned PERM_DEPTH       = 256;
   localparam int unsigned IDX_W            = 8;
   localparam int unsigned ROUND_COUNT      = 4;
   localparam int unsigned STEP_W           = $clog2(ROUND_COUNT + 1);
   localparam int unsigned SEED_MUL         = 19916032;
   localparam int unsigned SEED_DIV         = 131;
   localparam int unsigned SEED_STEP_Q      = (SEED_MUL / SEED_DIV) % 256;
   localparam int unsigned SEED_STEP_R      = SEED_MUL % SEED_DIV;
   localparam int unsigned KEY_MIX_MUL      = 7;
   localparam int unsigned KEY_MIX_OFF      = 13;
   localparam int unsigned ROUND_KEY_STRIDE = 17;
   localparam logic [7:0]  MASK_BYTE        = 8'h10;
   localparam int unsigned CSR_W            = 64;
   localparam int unsigned CSR_IDX_W        = 2;
   localparam int unsigned LENGTH_W         = 32;

   localparam logic FUNC_DERIVE = 1'b0;
   localparam logic FUNC_DATA   = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEED_LOW  = 2'd0,
      CSR_SEED_HIGH = 2'd1,
      CSR_LENGTH    = 2'd2,
      CSR_DIRECTION = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KEY_SEED,
      ST_KEY_XOR,
      ST_KEY_PRE,
      ST_KEY_MIX,
      ST_PERM_INIT,
      ST_PERM_SWAP,
      ST_PERM_INV,
      ST_KEY_MASK,
      ST_ROUND,
      ST_FINAL,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/core/kbrc_req_if.sv =====
// Request channel interface: command and data byte.
interface kbrc_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink (input valid, input func, input data_byte, output ready);
endinterface

// ===== rtl/core/kbrc_rsp_if.sv =====
// Response channel interface: result byte and table status.
interface kbrc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] result_byte;
   logic       tables_ready;

   modport source (output valid, output result_byte, output tables_ready, input ready);
   modport sink (input valid, input result_byte, input tables_ready, output ready);
endinterface

// ===== rtl/core/keyed_byte_round_cipher.sv =====
// Keyed byte round cipher: table derivation sequencer and round datapath.
//
// A request carries func and data_byte. A derive request (func 0) expands
// the seed registers into the key table and the forward and inverse byte
// permutations, clears the position counter and answers with a zero byte and
// tables_ready set. A data request (func 1) encrypts or decrypts one byte
// according to the direction register. Every request gives exactly one
// response transfer.
// A data byte passes ST_ROUND once per round, each round working on the
// registered reads of the key and permutation memories; a decrypt byte then
// passes ST_FINAL for its last inverse permutation read, and both end in
// ST_DONE. A derive spends the largest share of its time in the swap
// shuffle, which spends four permutation memory accesses on each entry.
// One request is worked on at a time; a new request is taken in the cycle
// after the previous result is loaded, so the core takes no new byte before
// it is through with the last one.
// If the receiver stalls with a result still waiting, the next result holds
// in the core until the output register frees up.
// Reset clears the control state, the position counter and the ready flag;
// the tables hold no meaning until a derive has run.
module keyed_byte_round_cipher (
   input  logic                                clock,
   input  logic                                reset,
   kbrc_req_if.sink                            req,
   kbrc_rsp_if.source                          rsp,
   input  logic                                csr_write_enable,
   input  logic [kbrc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kbrc_pkg::CSR_W-1:0]          csr_write_data
);

`include "keyed_byte_round_cipher_assert.svh"

   localparam int unsigned KW = kbrc_pkg::KEY_IDX_W;
   localparam int unsigned SW = kbrc_pkg::STEP_W;

   // Configuration registers.
   logic [63:0]                     seed_low_ff;
   logic [63:0]                     seed_high_ff;
   logic [kbrc_pkg::LENGTH_W-1:0]   length_ff;
   logic                            direction_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_low_ff  <= '0;
         seed_high_ff <= '0;
         length_ff    <= kbrc_pkg::LENGTH_W'(1);
         direction_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (kbrc_pkg::csr_index_type'(csr_index))
            kbrc_pkg::CSR_SEED_LOW:  seed_low_ff  <= csr_write_data;
            kbrc_pkg::CSR_SEED_HIGH: seed_high_ff <= csr_write_data;
            kbrc_pkg::CSR_LENGTH:    length_ff    <= csr_write_data[kbrc_pkg::LENGTH_W-1:0];
            kbrc_pkg::CSR_DIRECTION: direction_ff <= csr_write_data[0];
         endcase
      end
   end

   // Memories and their ports.
   logic [7:0]    ks_mem  [kbrc_pkg::KEY_DEPTH];
   logic [7:0]    fw_mem  [kbrc_pkg::PERM_DEPTH];
   logic [7:0]    inv_mem [kbrc_pkg::PERM_DEPTH];

   logic [KW-1:0] ks_ra_addr, ks_rb_addr, ks_waddr;
   logic          ks_we;
   logic [7:0]    ks_wdata, ks_ra_ff, ks_rb_ff;
   logic [7:0]    fw_raddr, fw_waddr, fw_wdata, fw_rd_ff;
   logic          fw_we;
   logic [7:0]    inv_raddr, inv_waddr, inv_wdata, inv_rd_ff;
   logic          inv_we;

   always_ff @(posedge clock) begin
      if (ks_we) begin
         ks_mem[ks_waddr] <= ks_wdata;
      end
      ks_ra_ff <= ks_mem[ks_ra_addr];
      ks_rb_ff <= ks_mem[ks_rb_addr];
   end

   always_ff @(posedge clock) begin
      if (fw_we) begin
         fw_mem[fw_waddr] <= fw_wdata;
      end
      fw_rd_ff <= fw_mem[fw_raddr];
   end

   always_ff @(posedge clock) begin
      if (inv_we) begin
         inv_mem[inv_waddr] <= inv_wdata;
      end
      inv_rd_ff <= inv_mem[inv_raddr];
   end

   // Sequencer registers.
   kbrc_pkg::state_type state_ff, state_in;
   logic [1:0]          sub_ff, sub_in;
   logic [7:0]          idx_ff, idx_in;
   logic [SW-1:0]       step_ff, step_in;
   logic [7:0]          t8_ff, t8_in;
   logic [7:0]          trem_ff, trem_in;
   logic [7:0]          j_ff, j_in;
   logic [7:0]          fi_ff, fi_in;
   logic [7:0]          prev_ff, prev_in;
   logic [7:0]          data_ff, data_in;
   logic [7:0]          res_ff, res_in;
   logic                is_derive_ff, is_derive_in;
   logic [KW-1:0]       pos_ff, pos_in;
   logic                ready_flag_ff, ready_flag_in;
   logic                rsp_valid_ff;
   logic [7:0]          rsp_result_ff;
   logic                rsp_tables_ff;
   logic                out_load;
   logic                out_free;

   function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [3:0] s);
      logic [15:0] w;
      w = {v, v} << s;
      return w[15:8];
   endfunction

   function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [3:0] s);
      logic [15:0] w;
      w = {v, v} >> s;
      return w[7:0];
   endfunction

   function automatic logic [7:0] round_of(input logic [SW-1:0] s, input logic dec);
      return dec ? (8'(kbrc_pkg::ROUND_COUNT - 1) - 8'(s)) : 8'(s);
   endfunction

   logic [127:0]  seed_cat;
   logic [7:0]    seed_sel;
   logic [KW-1:0] ki;
   logic          key_last;
   logic          perm_last;
   logic [7:0]    rc;
   logic [31:0]   mix;
   logic [7:0]    carry;
   logic [3:0]    sh;
   logic [7:0]    add_v;
   logic [7:0]    v_enc;
   logic [7:0]    v_in;
   logic [7:0]    u_dec;
   logic [7:0]    tmp_a, tmp_b;
   logic [7:0]    rnext;
   logic [KW-1:0] key_addr_next;
   logic [7:0]    jn;
   logic [7:0]    rot_one;
   logic [8:0]    trem_sum;

   assign seed_cat  = {seed_high_ff, seed_low_ff};
   assign seed_sel  = seed_cat[{idx_ff[3:0], 3'b000} +: 8];
   assign ki        = idx_ff[KW-1:0];
   assign key_last  = (idx_ff == 8'(kbrc_pkg::KEY_DEPTH - 1));
   assign perm_last = (idx_ff == 8'(kbrc_pkg::PERM_DEPTH - 1));
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == kbrc_pkg::ST_IDLE);

   // Round datapath: ks_ra_ff holds the key byte of the round being finished.
   always_comb begin
      rc    = round_of(step_ff - SW'(1), direction_ff);
      mix   = 32'(ks_ra_ff) + length_ff + 32'(rc);
      carry = mix[15:8];
      sh    = {1'b0, mix[2:0]} + 4'd1;
      add_v = mix[7:0] + rc;
      tmp_a = rotl8(fw_rd_ff + add_v, sh) ^ carry;
      v_enc = tmp_a + rc + carry;
      v_in  = (step_ff == SW'(1)) ? data_ff : inv_rd_ff;
      tmp_b = (v_in - rc - carry) ^ carry;
      u_dec = rotr8(tmp_b, sh) - add_v;
      rnext = round_of(step_ff, direction_ff);
      key_addr_next = KW'(32'(rnext) * kbrc_pkg::ROUND_KEY_STRIDE + 32'(pos_ff));
   end

   always_comb begin
      state_in      = state_ff;
      sub_in        = sub_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      t8_in         = t8_ff;
      trem_in       = trem_ff;
      j_in          = j_ff;
      fi_in         = fi_ff;
      prev_in       = prev_ff;
      data_in       = data_ff;
      res_in        = res_ff;
      is_derive_in  = is_derive_ff;
      pos_in        = pos_ff;
      ready_flag_in = ready_flag_ff;
      out_load      = 1'b0;
      ks_ra_addr    = '0;
      ks_rb_addr    = '0;
      ks_we         = 1'b0;
      ks_waddr      = ki;
      ks_wdata      = '0;
      fw_raddr      = '0;
      fw_we         = 1'b0;
      fw_waddr      = idx_ff;
      fw_wdata      = '0;
      inv_raddr     = '0;
      inv_we        = 1'b0;
      inv_waddr     = '0;
      inv_wdata     = '0;
      jn            = '0;
      rot_one       = '0;
      trem_sum      = '0;

      unique case (state_ff)
         kbrc_pkg::ST_IDLE: begin
            if (req.valid) begin
               if (req.func == kbrc_pkg::FUNC_DERIVE) begin
                  is_derive_in = 1'b1;
                  idx_in       = '0;
                  sub_in       = '0;
                  t8_in        = 8'(kbrc_pkg::SEED_STEP_Q);
                  trem_in      = 8'(kbrc_pkg::SEED_STEP_R);
                  state_in     = kbrc_pkg::ST_KEY_SEED;
               end else begin
                  is_derive_in = 1'b0;
                  data_in      = req.data_byte;
                  ks_ra_addr   = KW'(32'(round_of('0, direction_ff))
                                     * kbrc_pkg::ROUND_KEY_STRIDE + 32'(pos_ff));
                  fw_raddr     = req.data_byte;
                  step_in      = SW'(1);
                  state_in     = kbrc_pkg::ST_ROUND;
               end
            end
         end

         kbrc_pkg::ST_KEY_SEED: begin
            ks_we    = 1'b1;
            ks_wdata = seed_sel + t8_ff;
            trem_sum = 9'(trem_ff) + 9'(kbrc_pkg::SEED_STEP_R);
            if (trem_sum >= 9'(kbrc_pkg::SEED_DIV)) begin
               trem_in = 8'(trem_sum - 9'(kbrc_pkg::SEED_DIV));
               t8_in   = t8_ff + 8'(kbrc_pkg::SEED_STEP_Q) + 8'd1;
            end else begin
               trem_in = trem_sum[7:0];
               t8_in   = t8_ff + 8'(kbrc_pkg::SEED_STEP_Q);
            end
            if (key_last) begin
               idx_in   = '0;
               state_in = kbrc_pkg::ST_KEY_XOR;
            end else begin
               idx_in = idx_ff + 8'd1;
            end
         end

         kbrc_pkg::ST_KEY_XOR: begin
            if (sub_ff == 2'd0) begin
               ks_ra_addr = KW'(32'(ki) * kbrc_pkg::KEY_MIX_MUL + kbrc_pkg::KEY_MIX_OFF);
               ks_rb_addr = ki;
               sub_in     = 2'd1;
            end else begin
               ks_we    = 1'b1;
               ks_wdata = ks_rb_ff ^ (idx_ff + ks_ra_ff);
               sub_in   = 2'd0;
               if (key_last) begin
                  idx_in   = '0;
                  state_in = kbrc_pkg::ST_KEY_PRE;
               end else begin
                  idx_in = idx_ff + 8'd1;
               end
            end
         end

         kbrc_pkg::ST_KEY_PRE: begin
            if (sub_ff == 2'd0) begin
               ks_ra_addr = KW'(kbrc_pkg::KEY_DEPTH - 1);
               sub_in     = 2'd1;
            end else begin
               prev_in  = ks_ra_ff;
               sub_in   = 2'd0;
               state_in = kbrc_pkg::ST_KEY_MIX;
            end
         end

         kbrc_pkg::ST_KEY_MIX: begin
            if (sub_ff == 2'd0) begin
               ks_ra_addr = ki;
               ks_rb_addr = ki + KW'(1);
               sub_in     = 2'd1;
            end else begin
               rot_one  = rotl8(ks_ra_ff, 4'd1);
               ks_we    = 1'b1;
               ks_wdata = (prev_ff + ks_ra_ff + ks_rb_ff) ^ rot_one;
               prev_in  = ks_wdata;
               sub_in   = 2'd0;
               if (key_last) begin
                  idx_in   = '0;
                  state_in = kbrc_pkg::ST_PERM_INIT;
               end else begin
                  idx_in = idx_ff + 8'd1;
               end
            end
         end

         kbrc_pkg::ST_PERM_INIT: begin
            fw_we    = 1'b1;
            fw_wdata = idx_ff;
            idx_in   = idx_ff + 8'd1;
            if (perm_last) begin
               j_in     = '0;
               sub_in   = 2'd0;
               state_in = kbrc_pkg::ST_PERM_SWAP;
            end
         end

         kbrc_pkg::ST_PERM_SWAP: begin
            unique case (sub_ff)
               2'd0: begin
                  fw_raddr = idx_ff;
                  sub_in   = 2'd1;
               end
               2'd1: begin
                  jn       = j_ff + fw_rd_ff + seed_sel;
                  j_in     = jn;
                  fi_in    = fw_rd_ff;
                  fw_raddr = jn;
                  sub_in   = 2'd2;
               end
               2'd2: begin
                  fw_we    = 1'b1;
                  fw_wdata = fw_rd_ff;
                  sub_in   = 2'd3;
               end
               default: begin
                  fw_we    = 1'b1;
                  fw_waddr = j_ff;
                  fw_wdata = fi_ff;
                  sub_in   = 2'd0;
                  idx_in   = idx_ff + 8'd1;
                  if (perm_last) begin
                     state_in = kbrc_pkg::ST_PERM_INV;
                  end
               end
            endcase
         end

         kbrc_pkg::ST_PERM_INV: begin
            if (sub_ff == 2'd0) begin
               fw_raddr = idx_ff;
               sub_in   = 2'd1;
            end else begin
               inv_we    = 1'b1;
               inv_waddr = fw_rd_ff;
               inv_wdata = idx_ff;
               sub_in    = 2'd0;
               idx_in    = idx_ff + 8'd1;
               if (perm_last) begin
                  state_in = kbrc_pkg::ST_KEY_MASK;
               end
            end
         end

         kbrc_pkg::ST_KEY_MASK: begin
            unique case (sub_ff)
               2'd0: begin
                  ks_ra_addr = ki;
                  sub_in     = 2'd1;
               end
               2'd1: begin
                  fw_raddr = ks_ra_ff;
                  sub_in   = 2'd2;
               end
               default: begin
                  ks_we    = 1'b1;
                  ks_wdata = fw_rd_ff ^ ((idx_ff[1:0] == 2'd0) ? kbrc_pkg::MASK_BYTE : 8'd0);
                  sub_in   = 2'd0;
                  if (key_last) begin
                     idx_in   = '0;
                     res_in   = '0;
                     state_in = kbrc_pkg::ST_DONE;
                  end else begin
                     idx_in = idx_ff + 8'd1;
                  end
               end
            endcase
         end

         kbrc_pkg::ST_ROUND: begin
            if (step_ff == SW'(kbrc_pkg::ROUND_COUNT)) begin
               if (direction_ff) begin
                  inv_raddr = u_dec;
                  state_in  = kbrc_pkg::ST_FINAL;
               end else begin
                  res_in   = v_enc;
                  state_in = kbrc_pkg::ST_DONE;
               end
            end else begin
               ks_ra_addr = key_addr_next;
               fw_raddr   = v_enc;
               inv_raddr  = u_dec;
               step_in    = step_ff + SW'(1);
            end
         end

         kbrc_pkg::ST_FINAL: begin
            res_in   = inv_rd_ff;
            state_in = kbrc_pkg::ST_DONE;
         end

         kbrc_pkg::ST_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = kbrc_pkg::ST_IDLE;
               if (is_derive_ff) begin
                  ready_flag_in = 1'b1;
                  pos_in        = '0;
               end else begin
                  pos_in = pos_ff + KW'(1);
               end
            end
         end

         default: begin
            state_in = kbrc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kbrc_pkg::ST_IDLE;
         sub_ff        <= '0;
         idx_ff        <= '0;
         step_ff       <= '0;
         is_derive_ff  <= 1'b0;
         pos_ff        <= '0;
         ready_flag_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sub_ff        <= sub_in;
         idx_ff        <= idx_in;
         step_ff       <= step_in;
         is_derive_ff  <= is_derive_in;
         pos_ff        <= pos_in;
         ready_flag_ff <= ready_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      t8_ff   <= t8_in;
      trem_ff <= trem_in;
      j_ff    <= j_in;
      fi_ff   <= fi_in;
      prev_ff <= prev_in;
      data_ff <= data_in;
      res_ff  <= res_in;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_result_ff <= res_ff;
         rsp_tables_ff <= is_derive_ff | ready_flag_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_byte  = rsp_result_ff;
   assign rsp.tables_ready = rsp_tables_ff;

   `KBRC_ASSERT_NEXT(a_accept_goes_busy, clock, reset,
      req.valid && req.ready, state_ff != kbrc_pkg::ST_IDLE,
      "Accepted request did not leave the idle state")
   `KBRC_ASSERT_NOW(a_step_in_range, clock, reset,
      state_ff == kbrc_pkg::ST_ROUND,
      step_ff >= SW'(1) && step_ff <= SW'(kbrc_pkg::ROUND_COUNT),
      "Round step counter out of range")
   `KBRC_ASSERT_NEXT(a_done_loads_output, clock, reset,
      state_ff == kbrc_pkg::ST_DONE && out_free, rsp_valid_ff && state_ff == kbrc_pkg::ST_IDLE,
      "Finished result was not loaded into the output register")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the keyed byte round cipher with a built-in predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kbrc_pkg::*;

   localparam int unsigned IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [7:0] result_byte;
      logic       tables_ready;
   } cipher_reply_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_write_data;

   kbrc_req_if req ();
   kbrc_rsp_if rsp ();

   keyed_byte_round_cipher i_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Predicted copy of the registers and tables.
   logic [63:0] seed_lo_q, seed_hi_q;
   logic [31:0] length_q;
   logic        decrypt_q;
   logic [7:0]  key_tab [KEY_DEPTH];
   logic [7:0]  fwd_perm [256];
   logic [7:0]  rev_perm [256];
   logic [KEY_IDX_W-1:0] position_q;
   logic        derived_q;

   cipher_reply_type replies_due [$];
   int unsigned error_count;
   int unsigned idle_cycles;
   int unsigned send_gap_max;
   int unsigned stall_max;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] seed_byte(int unsigned i);
      logic [63:0] w;
      w = ((i & 15) < 8) ? seed_lo_q : seed_hi_q;
      return w[(i & 7) * 8 +: 8];
   endfunction

   function automatic logic [7:0] rotl8(logic [7:0] v, int unsigned s);
      logic [15:0] d;
      d = {v, v} << s;
      return d[15:8];
   endfunction

   function automatic logic [7:0] rotr8(logic [7:0] v, int unsigned s);
      logic [15:0] d;
      d = {v, v} >> s;
      return d[7:0];
   endfunction

   function automatic void derive_tables();
      longint unsigned t;
      logic [7:0] o, p, c, x, tmp;
      logic [7:0] j;
      for (int unsigned i = 0; i < KEY_DEPTH; i++) begin
         t = (64'd19916032 * (i + 1)) / 131;
         key_tab[i] = seed_byte(i) + t[7:0];
      end
      for (int unsigned i = 0; i < KEY_DEPTH; i++) begin
         o = key_tab[(7 * i + 13) % KEY_DEPTH];
         key_tab[i] = key_tab[i] ^ (8'(i) + o);
      end
      for (int unsigned i = 0; i < KEY_DEPTH; i++) begin
         p = key_tab[(KEY_DEPTH + i - 1) % KEY_DEPTH];
         c = key_tab[i];
         x = key_tab[(i + 1) % KEY_DEPTH];
         key_tab[i] = (p + c + x) ^ rotl8(c, 1);
      end
      for (int unsigned i = 0; i < 256; i++) fwd_perm[i] = 8'(i);
      j = 8'd0;
      for (int unsigned i = 0; i < 256; i++) begin
         j = j + fwd_perm[i] + seed_byte(i);
         tmp = fwd_perm[i];
         fwd_perm[i] = fwd_perm[j];
         fwd_perm[j] = tmp;
      end
      for (int unsigned i = 0; i < 256; i++) rev_perm[fwd_perm[i]] = 8'(i);
      for (int unsigned i = 0; i < KEY_DEPTH; i++)
         key_tab[i] = (((i & 3) == 0) ? MASK_BYTE : 8'h00) ^ fwd_perm[key_tab[i]];
   endfunction

   function automatic logic [7:0] cipher_byte(logic [7:0] v_in);
      logic [7:0] v, carry, add;
      logic [31:0] mix;
      int unsigned r, sh;
      v = v_in;
      for (int unsigned step = 0; step < ROUND_COUNT; step++) begin
         r = decrypt_q ? (ROUND_COUNT - 1 - step) : step;
         mix = 32'(key_tab[(17 * r + position_q) % KEY_DEPTH]) + length_q + 32'(r);
         carry = mix[15:8];
         sh = mix[2:0] + 1;
         add = mix[7:0] + 8'(r);
         if (!decrypt_q) begin
            v = fwd_perm[v];
            v = rotl8(v + add, sh) ^ carry;
            v = v + 8'(r) + carry;
         end else begin
            v = (v - 8'(r) - carry) ^ carry;
            v = rotr8(v, sh) - add;
            v = rev_perm[v];
         end
      end
      return v;
   endfunction

   function automatic cipher_reply_type predict_reply(logic f, logic [7:0] b);
      cipher_reply_type e;
      e.result_byte = 8'h00;
      if (f == FUNC_DERIVE) begin
         derive_tables();
         position_q = '0;
         derived_q = 1'b1;
      end else begin
         e.result_byte = cipher_byte(b);
         position_q = position_q + 1'b1;
      end
      e.tables_ready = derived_q;
      return e;
   endfunction

   task automatic send_item(logic f, logic [7:0] b);
      int unsigned gap;
      gap = $urandom_range(send_gap_max, 0);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.func <= f;
      req.data_byte <= b;
      do @(posedge clock); while (!req.ready);
      replies_due.push_back(predict_reply(f, b));
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (replies_due.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [63:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_SEED_LOW:  seed_lo_q = value;
         CSR_SEED_HIGH: seed_hi_q = value;
         CSR_LENGTH:    length_q = value[31:0];
         CSR_DIRECTION: decrypt_q = value[0];
      endcase
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_bytes(int unsigned count);
      for (int unsigned k = 0; k < count; k++) send_item(FUNC_DATA, 8'($urandom));
   endtask

   task automatic test_extremes();
      drain();
      write_csr(CSR_SEED_LOW, 64'd0);
      write_csr(CSR_SEED_HIGH, 64'd0);
      send_item(FUNC_DERIVE, 8'hff);
      send_item(FUNC_DATA, 8'h00);
      send_item(FUNC_DATA, 8'hff);
      drain();
      write_csr(CSR_SEED_LOW, '1);
      write_csr(CSR_SEED_HIGH, '1);
      write_csr(CSR_LENGTH, 64'hffff_ffff);
      send_item(FUNC_DERIVE, 8'h00);
      send_item(FUNC_DATA, 8'h80);
      send_item(FUNC_DATA, 8'h01);
      drain();
      write_csr(CSR_DIRECTION, 64'd1);
      write_csr(CSR_LENGTH, 64'd0);
      send_item(FUNC_DATA, 8'hff);
      send_item(FUNC_DATA, 8'h00);
      send_item(FUNC_DATA, 8'h7f);
   endtask

   task automatic test_seed_without_derive();
      drain();
      write_csr(CSR_SEED_LOW, rand64());
      write_csr(CSR_SEED_HIGH, rand64());
      write_csr(CSR_DIRECTION, 64'd0);
      send_item(FUNC_DATA, 8'h5a);
      send_item(FUNC_DATA, 8'ha5);
   endtask

   task automatic test_direction_switch();
      for (int unsigned k = 0; k < 4; k++) begin
         drain();
         write_csr(CSR_DIRECTION, 64'(k & 1));
         send_bytes(2);
      end
   endtask

   task automatic test_position_wrap();
      drain();
      write_csr(CSR_LENGTH, 64'd1);
      send_item(FUNC_DERIVE, 8'($urandom));
      send_bytes(KEY_DEPTH + 10);
   endtask

   task automatic test_no_idle();
      drain();
      send_gap_max = 0;
      stall_max = 0;
      send_bytes(80);
      drain();
      send_gap_max = 16;
      stall_max = 16;
   endtask

   task automatic test_random_streams();
      int unsigned sent;
      sent = 0;
      while (sent < 1100) begin
         drain();
         write_csr(CSR_SEED_LOW, rand64());
         write_csr(CSR_SEED_HIGH, rand64());
         case ($urandom_range(3, 0))
            0: write_csr(CSR_LENGTH, 64'($urandom_range(255, 1)));
            1: write_csr(CSR_LENGTH, 64'hffff_ff00 | 64'($urandom_range(255, 0)));
            default: write_csr(CSR_LENGTH, 64'($urandom));
         endcase
         write_csr(CSR_DIRECTION, 64'($urandom_range(1, 0)));
         if ($urandom_range(4, 0) != 0) send_item(FUNC_DERIVE, 8'($urandom));
         for (int unsigned k = $urandom_range(60, 15); k > 0; k--) begin
            send_item(FUNC_DATA, 8'($urandom));
            sent++;
            if ($urandom_range(40, 0) == 0) drain();
         end
      end
   endtask

   always @(posedge clock) begin
      cipher_reply_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (replies_due.size() == 0) begin
            $display("%0t: unexpected transfer, result %h ready %b", $time,
                     rsp.result_byte, rsp.tables_ready);
            error_count++;
         end else begin
            e = replies_due.pop_front();
            if (rsp.result_byte !== e.result_byte) begin
               $display("%0t: result_byte expected %h actual %h", $time,
                        e.result_byte, rsp.result_byte);
               error_count++;
            end
            if (rsp.tables_ready !== e.tables_ready) begin
               $display("%0t: tables_ready expected %b actual %b", $time,
                        e.tables_ready, rsp.tables_ready);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned stall;
      rsp.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = $urandom_range(stall_max, 0);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
      end
   end

   initial begin
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.func <= FUNC_DERIVE;
      req.data_byte <= 8'h00;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_SEED_LOW;
      csr_write_data <= '0;
      seed_lo_q = '0;
      seed_hi_q = '0;
      length_q = 32'd1;
      decrypt_q = 1'b0;
      position_q = '0;
      derived_q = 1'b0;
      error_count = 0;
      idle_cycles = 0;
      send_gap_max = 16;
      stall_max = 16;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_seed_without_derive();
      test_direction_switch();
      test_position_wrap();
      test_no_idle();
      test_random_streams();
      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0 && replies_due.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule
